@@ sv/glu_pkg.sv @@
// Package for the GCD/LCM unit: payload structs, sequencer states, default width.
`timescale 1ns / 1ps

package glu_pkg;

  localparam int unsigned DataWidthDefault = 32;

  typedef struct packed {
    logic signed [31:0] a_value;
    logic signed [31:0] b_value;
  } glu_req_t;

  typedef struct packed {
    logic        status;
    logic [30:0] gcd_result;
    logic [61:0] lcm_result;
  } glu_rsp_t;

  localparam logic StatusOk      = 1'b0;
  localparam logic StatusInvalid = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_ODDX,
    ST_LOOP,
    ST_SHL,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } glu_state_e;

endpackage

@@ sv/gcd_lcm_unit_top.sv @@
// GCD/LCM unit: binary GCD, restoring divide and shift-add multiply on one adder.
//
//   channel   | handshake        | payload          | notes
//   ----------+------------------+------------------+-----------------------------
//   command   | start, busy      | req_i (a, b)     | beat taken when start & !busy
//   result    | done_o           | rsp_o            | one-cycle strobe, no stall
//
// A beat with a non-positive operand returns status invalid in the following cycle.
// A valid beat, once taken, strips s common factors of two (later restored by the left
// shift), halves a k more times, and runs the binary GCD loop, one step for each
// halving, subtract or swap. Then DATA_WIDTH divide and DATA_WIDTH multiply steps
// run on the same adder.
// Reset clears the sequencer and the strobe; busy stays high until the result.
`timescale 1ns / 1ps

module gcd_lcm_unit_top #(
  parameter int unsigned DATA_WIDTH = glu_pkg::DataWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  glu_pkg::glu_req_t req_i,
  output logic              done_o,
  output glu_pkg::glu_rsp_t rsp_o
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned CW = $clog2(DW + 1);

  glu_pkg::glu_state_e state_q, state_d;

  logic [DW-1:0]   x_q, x_d;
  logic [DW-1:0]   y_q, y_d;
  logic [DW-1:0]   a_q, a_d;
  logic [DW-1:0]   b_q, b_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [2*DW-1:0] prod_q, prod_d;
  logic [CW-1:0]   sh_q, sh_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            done_q, done_d;
  glu_pkg::glu_rsp_t rsp_q, rsp_d;

  // shared adder/subtractor
  logic [DW:0] alu_a, alu_b, alu_res;
  logic        alu_sub;

  logic [DW-1:0] a_w, b_w;
  logic          a_ok, b_ok;
  logic [DW-1:0] div_shift;
  logic          alu_neg;

  assign a_w  = req_i.a_value[DW-1:0];
  assign b_w  = req_i.b_value[DW-1:0];
  assign a_ok = (a_w != '0) && !a_w[DW-1];
  assign b_ok = (b_w != '0) && !b_w[DW-1];

  // remainder stays below the divisor, so the shifted value fits in DW bits
  assign div_shift = {rem_q[DW-2:0], quo_q[DW-1]};

  assign alu_res = alu_a + (alu_b ^ {(DW+1){alu_sub}}) + (DW+1)'(alu_sub);
  assign alu_neg = alu_res[DW];

  always_comb begin
    unique case (state_q)
      glu_pkg::ST_DIV: begin
        alu_a   = {1'b0, div_shift};
        alu_b   = {1'b0, x_q};
        alu_sub = 1'b1;
      end
      glu_pkg::ST_MUL: begin
        alu_a   = {1'b0, prod_q[2*DW-1:DW]};
        alu_b   = {1'b0, b_q};
        alu_sub = 1'b0;
      end
      default: begin
        alu_a   = {1'b0, y_q};
        alu_b   = {1'b0, x_q};
        alu_sub = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glu_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    a_q    <= a_d;
    b_q    <= b_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    prod_q <= prod_d;
    sh_q   <= sh_d;
    cnt_q  <= cnt_d;
    rsp_q  <= rsp_d;
  end

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    a_d     = a_q;
    b_d     = b_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    prod_d  = prod_q;
    sh_d    = sh_q;
    cnt_d   = cnt_q;
    rsp_d   = rsp_q;
    done_d  = 1'b0;

    unique case (state_q)
      glu_pkg::ST_IDLE: begin
        if (start) begin
          if (a_ok && b_ok) begin
            x_d     = a_w;
            y_d     = b_w;
            a_d     = a_w;
            b_d     = b_w;
            sh_d    = '0;
            state_d = glu_pkg::ST_STRIP;
          end else begin
            rsp_d.status     = glu_pkg::StatusInvalid;
            rsp_d.gcd_result = '0;
            rsp_d.lcm_result = '0;
            done_d           = 1'b1;
          end
        end
      end
      glu_pkg::ST_STRIP: begin
        // drop common factors of two
        if (!x_q[0] && !y_q[0]) begin
          x_d  = x_q >> 1;
          y_d  = y_q >> 1;
          sh_d = sh_q + CW'(1);
        end else begin
          state_d = glu_pkg::ST_ODDX;
        end
      end
      glu_pkg::ST_ODDX: begin
        if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else begin
          state_d = glu_pkg::ST_LOOP;
        end
      end
      glu_pkg::ST_LOOP: begin
        if (y_q == '0) begin
          state_d = glu_pkg::ST_SHL;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (alu_neg) begin
          // x > y: swap, subtract on the next step
          x_d = y_q;
          y_d = x_q;
        end else begin
          y_d = alu_res[DW-1:0];
        end
      end
      glu_pkg::ST_SHL: begin
        if (sh_q == '0) begin
          rem_d   = '0;
          quo_d   = a_q;
          cnt_d   = '0;
          state_d = glu_pkg::ST_DIV;
        end else begin
          x_d  = x_q << 1;
          sh_d = sh_q - CW'(1);
        end
      end
      glu_pkg::ST_DIV: begin
        rem_d = alu_neg ? div_shift : alu_res[DW-1:0];
        quo_d = {quo_q[DW-2:0], !alu_neg};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(DW - 1)) begin
          prod_d  = {{DW{1'b0}}, quo_q[DW-2:0], !alu_neg};
          cnt_d   = '0;
          state_d = glu_pkg::ST_MUL;
        end
      end
      glu_pkg::ST_MUL: begin
        // add b into the upper half when the low bit is set, then shift right
        if (prod_q[0]) begin
          prod_d = {alu_res, prod_q[DW-1:1]};
        end else begin
          prod_d = {1'b0, prod_q[2*DW-1:DW], prod_q[DW-1:1]};
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(DW - 1)) begin
          state_d = glu_pkg::ST_FIN;
        end
      end
      glu_pkg::ST_FIN: begin
        rsp_d.status     = glu_pkg::StatusOk;
        rsp_d.gcd_result = 31'(x_q);
        rsp_d.lcm_result = 62'(prod_q);
        done_d           = 1'b1;
        state_d          = glu_pkg::ST_IDLE;
      end
      default: begin
        state_d = glu_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != glu_pkg::ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

@@ sv/glu_chk.sv @@
// Port-level checks for the GCD/LCM unit, bound to the top level.
`timescale 1ns / 1ps

module glu_chk #(
  parameter int unsigned DATA_WIDTH = glu_pkg::DataWidthDefault
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input glu_pkg::glu_req_t req_i,
  input logic              done_o,
  input glu_pkg::glu_rsp_t rsp_o
);

  logic [DATA_WIDTH-1:0] a_w, b_w;
  logic                  ops_ok;

  assign a_w    = req_i.a_value[DATA_WIDTH-1:0];
  assign b_w    = req_i.b_value[DATA_WIDTH-1:0];
  assign ops_ok = (a_w != '0) && !a_w[DATA_WIDTH-1] && (b_w != '0) && !b_w[DATA_WIDTH-1];

  // a result beat always ends the job
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while busy");

  a_bad_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !ops_ok) |=> (done_o && rsp_o.status == glu_pkg::StatusInvalid))
    else $error("invalid operands not flagged on the next cycle");

  a_good_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && ops_ok) |=> (busy && !done_o))
    else $error("valid command did not start a job");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == glu_pkg::StatusInvalid) |->
      (rsp_o.gcd_result == '0 && rsp_o.lcm_result == '0))
    else $error("invalid result carries nonzero values");

  a_good_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == glu_pkg::StatusOk) |->
      (rsp_o.gcd_result != '0 && rsp_o.lcm_result != '0))
    else $error("valid result with zero gcd or lcm");

endmodule

bind gcd_lcm_unit_top glu_chk #(.DATA_WIDTH(DATA_WIDTH)) u_glu_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
